// ===== src/sfmt_pkg.sv =====
package sfmt_pkg;

    localparam int NUM_ALARMS = 5;
    localparam int TIME_W = 17;
    localparam int TIMER_W = 8;
    localparam int LOAD_W = 10;
    localparam int TARGET_W = 13;
    localparam int MEALS_W = 3;
    localparam int WEIGHT_W = 14;
    localparam int QTY_W = 10;
    localparam int MODE_W = 2;
    localparam int RECIP_W = 19;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W = 32;
    localparam int IN_USER_W = 2;
    localparam int OUT_DATA_W = 40;

    localparam logic [TIMER_W-1:0] RUN_LIMIT = 8'd20;
    localparam logic [TIMER_W-1:0] TIMER_MAX = 8'd255;
    localparam logic [TIME_W-1:0] SECONDS_PER_DAY = 17'd86400;
    localparam logic [TIME_W-1:0] LAST_SECOND = 17'd86399;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_SET_CLOCK = 2'd1;
    localparam logic [1:0] ACT_TOGGLE = 2'd2;
    localparam logic [1:0] ACT_SAMPLE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ONE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_FIVE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTITY = 3'd7;

    typedef struct packed {
        logic capture;
        logic prep;
        logic mul;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // Reciprocal of the meal count, scaled by 2^18, rounded up so that the
    // truncated product is the exact floor for every half weight in range.
    function automatic logic [RECIP_W-1:0] meal_recip(input logic [MEALS_W-1:0] meals);
        logic [RECIP_W-1:0] r;
        begin
            case (meals)
                3'd1: r = 19'd262144;
                3'd2: r = 19'd131072;
                3'd3: r = 19'd87382;
                3'd4: r = 19'd65536;
                3'd5: r = 19'd52429;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== src/scheduled_feed_motor_timer_top.sv =====
// A request is captured, then passes the update, multiply and commit steps
// of the sequencer; its result is registered at the commit step, and a new
// request is accepted only after that commit. A full output register holds
// the commit step until the result is taken.
// Reset: rst_n is asynchronous and active low; it clears the clock, run timer,
// feed and motor state, all configuration registers and the output valid flag.
module scheduled_feed_motor_timer_top
    import sfmt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // load_reading [9:0], new_time [26:10], zero fill above.
    input  logic [IN_DATA_W-1:0]   s_tdata,
    // action [1:0].
    input  logic [IN_USER_W-1:0]   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // motor_on [0], time_of_day [17:1], feeding [18], meals_used [21:19],
    // target_load [34:22], zero fill above.
    output logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [TIME_W-1:0]      cfg_data
);

    cmd_t    cmd;
    status_t status;

    sfmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sfmt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== src/sfmt_ctrl.sv =====
module sfmt_ctrl
    import sfmt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_MUL = 2'd2;
    localparam logic [1:0] S_LAW = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP: state_next = S_MUL;
            S_MUL: state_next = S_LAW;
            S_LAW:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign cmd.capture = s_tvalid && (state_reg == S_IDLE);
    assign cmd.prep = (state_reg == S_PREP);
    assign cmd.mul = (state_reg == S_MUL);
    assign cmd.commit = (state_reg == S_LAW) && status.out_free;

endmodule

// ===== src/sfmt_datapath.sv =====
module sfmt_datapath
    import sfmt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic [IN_USER_W-1:0]   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [TIME_W-1:0]      cfg_data
);

    logic [1:0]            action_reg;
    logic [LOAD_W-1:0]     load_reg;
    logic [TIME_W-1:0]     new_time_reg;

    logic [TIME_W-1:0]     alarm_reg [NUM_ALARMS];
    logic [MODE_W-1:0]     mode_reg;
    logic [WEIGHT_W-1:0]   weight_reg;
    logic [QTY_W-1:0]      quantity_reg;

    logic [TIME_W-1:0]     clock_reg;
    logic [TIME_W-1:0]     clock_next;
    logic [TIMER_W-1:0]    timer_reg;
    logic [TIMER_W-1:0]    timer_next;
    logic                  feed_reg;
    logic                  feed_next;
    logic                  motor_reg;
    logic                  motor_next;

    logic [MEALS_W-1:0]    meals_reg;
    logic [MEALS_W-1:0]    meals_next;
    logic [TARGET_W-1:0]   half_reg;
    logic [PROD_W-1:0]     product_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                  enabled;
    logic                  automatic_mode;
    logic [TARGET_W-1:0]   target;
    logic                  match;
    logic [TIMER_W-1:0]    timer_eff;
    logic                  feed_eff;
    logic                  run;
    logic [TIMER_W-1:0]    commit_timer;

    assign enabled = mode_reg[0];
    assign automatic_mode = mode_reg[1];

    always_comb
    begin
        meals_next = '0;
        match = 1'b0;
        for (int i = 0; i < NUM_ALARMS; i++)
        begin
            if (alarm_reg[i] != '0)
            begin
                meals_next = meals_next + 3'd1;
                if (alarm_reg[i] == clock_reg)
                begin
                    match = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        clock_next = clock_reg;
        timer_next = timer_reg;
        case (action_reg)
            ACT_TICK:
            begin
                clock_next = (clock_reg >= LAST_SECOND) ? '0 : clock_reg + 17'd1;
                if (timer_reg < TIMER_MAX)
                begin
                    timer_next = timer_reg + 8'd1;
                end
            end
            ACT_SET_CLOCK:
            begin
                if (new_time_reg < SECONDS_PER_DAY)
                begin
                    clock_next = new_time_reg;
                end
            end
            default:
            begin
                clock_next = clock_reg;
            end
        endcase
    end

    always_comb
    begin
        if (!automatic_mode)
        begin
            target = TARGET_W'(quantity_reg);
        end
        else if (meals_reg == '0)
        begin
            target = '0;
        end
        else
        begin
            target = product_reg[RECIP_SHIFT +: TARGET_W];
        end
    end

    assign timer_eff = match ? '0 : timer_reg;
    assign feed_eff = feed_reg || match;
    assign run = feed_eff && (timer_eff < RUN_LIMIT) && (TARGET_W'(load_reg) <= target);

    always_comb
    begin
        motor_next = motor_reg;
        feed_next = feed_reg;
        commit_timer = timer_reg;
        if (enabled)
        begin
            motor_next = run;
            feed_next = run;
            commit_timer = run ? timer_eff : '0;
        end
        else if (action_reg == ACT_TOGGLE)
        begin
            motor_next = !motor_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= s_tuser;
            load_reg <= s_tdata[LOAD_W-1:0];
            new_time_reg <= s_tdata[LOAD_W +: TIME_W];
        end
        if (cmd.prep)
        begin
            meals_reg <= meals_next;
            half_reg <= weight_reg[WEIGHT_W-1:1];
        end
        if (cmd.mul)
        begin
            product_reg <= PROD_W'(half_reg) * PROD_W'(meal_recip(meals_reg));
        end
        if (cmd.commit)
        begin
            out_data_reg <= {5'b0, target, meals_reg, feed_next, clock_reg, motor_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ALARMS; i++)
            begin
                alarm_reg[i] <= '0;
            end
            mode_reg <= '0;
            weight_reg <= '0;
            quantity_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index <= CFG_ALARM_FIVE)
            begin
                alarm_reg[cfg_index - CFG_ALARM_ONE] <= cfg_data;
            end
            else if (cfg_index == CFG_MODE)
            begin
                mode_reg <= cfg_data[MODE_W-1:0];
            end
            else if (cfg_index == CFG_WEIGHT)
            begin
                weight_reg <= cfg_data[WEIGHT_W-1:0];
            end
            else if (cfg_index == CFG_QUANTITY)
            begin
                quantity_reg <= cfg_data[QTY_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= '0;
            timer_reg <= '0;
            feed_reg <= 1'b0;
            motor_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.prep)
            begin
                clock_reg <= clock_next;
                timer_reg <= timer_next;
            end
            if (cmd.commit)
            begin
                timer_reg <= commit_timer;
                feed_reg <= feed_next;
                motor_reg <= motor_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && enabled |=> !motor_reg || (timer_reg < RUN_LIMIT))
        else $error("Motor running with run timer at or past the limit.");

    a_motor_feed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && enabled |=> motor_reg == feed_reg)
        else $error("Motor and feed cycle disagree under the scheduler.");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("Result appeared without a committed request.");

    a_timer_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && enabled && !feed_next |=> timer_reg == '0)
        else $error("Run timer not cleared when the feed cycle ended.");

endmodule
